>>> rtl/http_request_header_parser_assert.svh
// ----------------------------------------------------------------------------
// HTTP request header parser assertion macros
// Concurrent assertion wrappers used by the checker file hrp_checker.sv.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define HRP_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
    else $error("hrp: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define HRP_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
    else $error("hrp: next-cycle check failed");

`endif

>>> rtl/hrp_pkg.sv
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared limits, codes and beat types of the HTTP request header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrp_pkg;

  localparam int MAX_REQUEST_BYTES = 2048;
  localparam int MAX_PATH_CHARS    = 255;
  localparam int MAX_TOKEN_CHARS   = 15;

  localparam int TOTAL_W  = $clog2(MAX_REQUEST_BYTES + 1);
  localparam int TOK_MAX  = (MAX_PATH_CHARS > MAX_TOKEN_CHARS) ? MAX_PATH_CHARS
                                                                : MAX_TOKEN_CHARS;
  localparam int TOKLEN_W = $clog2(TOK_MAX + 1);

  localparam int LEN_W   = 31;
  localparam int DATA_W  = 8;
  localparam int STAT_W  = 2;
  localparam int KIND_W  = 2;

  localparam logic [STAT_W-1:0] STATUS_INCOMPLETE = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_COMPLETE   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD        = 2'd2;

  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PATH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BODY  = 2'd2;

  typedef struct packed {
    logic              func;
    logic [DATA_W-1:0] data_byte;
  } hrp_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              method_post;
    logic [LEN_W-1:0]  content_length;
    logic [DATA_W-1:0] byte_out;
    logic [KIND_W-1:0] byte_kind;
    logic              path_is_root;
  } hrp_result_t;

endpackage

`default_nettype wire

>>> rtl/hrp_parse_core.sv
// ----------------------------------------------------------------------------
// hrp_parse_core
// Parser state and the single-pass next-state logic for one request byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrp_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  hrp_pkg::hrp_item_t  item,
  output hrp_pkg::hrp_result_t res
);
  import hrp_pkg::*;

  typedef enum logic [2:0] {
    PH_LINE,
    PH_HEADER,
    PH_BODY,
    PH_DONE,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    NUM_PREFIX,
    NUM_SIGN,
    NUM_DIGITS,
    NUM_SKIP
  } num_phase_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int          HDR_LEN   = 15;
  localparam logic [3:0]  HDR_LAST  = 4'(HDR_LEN - 1);
  localparam logic [3:0]  HDR_FULL  = 4'(HDR_LEN);
  localparam logic [1:0]  TOK_SAT   = 2'd3;

  localparam logic [TOKLEN_W-1:0] TOKEN_LIMIT = TOKLEN_W'(MAX_TOKEN_CHARS);
  localparam logic [TOKLEN_W-1:0] PATH_LIMIT  = TOKLEN_W'(MAX_PATH_CHARS);
  localparam logic [TOKLEN_W-1:0] TOKLEN_SAT  = '1;
  localparam logic [TOTAL_W-1:0]  TOTAL_LIMIT = TOTAL_W'(MAX_REQUEST_BYTES);
  localparam logic [LEN_W-1:0]    LEN_MAX     = '1;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  function automatic logic [7:0] get_char(input logic [1:0] idx);
    case (idx)
      2'd0:    return 8'h67; // g
      2'd1:    return 8'h65; // e
      2'd2:    return 8'h74; // t
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] idx);
    case (idx)
      2'd0:    return 8'h70; // p
      2'd1:    return 8'h6F; // o
      2'd2:    return 8'h73; // s
      default: return 8'h74; // t
    endcase
  endfunction

  // lower-case "content-length:"
  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h63;
      4'd1:    return 8'h6F;
      4'd2:    return 8'h6E;
      4'd3:    return 8'h74;
      4'd4:    return 8'h65;
      4'd5:    return 8'h6E;
      4'd6:    return 8'h74;
      4'd7:    return 8'h2D;
      4'd8:    return 8'h6C;
      4'd9:    return 8'h65;
      4'd10:   return 8'h6E;
      4'd11:   return 8'h67;
      4'd12:   return 8'h74;
      4'd13:   return 8'h68;
      4'd14:   return 8'h3A;
      default: return 8'h00;
    endcase
  endfunction

  phase_t              phase_r, phase_nxt;
  logic                cr_r, cr_nxt;
  logic [1:0]          tn_r, tn_nxt;
  logic                in_tok_r, in_tok_nxt;
  logic [TOKLEN_W-1:0] tl_r, tl_nxt;
  logic [1:0]          mm_r, mm_nxt;
  logic                nonempty_r, nonempty_nxt;
  logic [3:0]          hmi_r, hmi_nxt;
  num_phase_t          np_r, np_nxt;
  logic                neg_r, neg_nxt;
  logic [LEN_W-1:0]    acc_r, acc_nxt;
  logic [LEN_W-1:0]    cl_r, cl_nxt;
  logic [LEN_W-1:0]    br_r, br_nxt;
  logic [TOTAL_W-1:0]  tb_r, tb_nxt;
  logic                root_r, root_nxt;
  logic                post_r, post_nxt;

  logic [7:0]          b;
  logic [7:0]          lc;
  logic                blank;
  logic                digit;
  logic [TOKLEN_W-1:0] tl_cur;
  logic                get_hit;
  logic                post_hit;
  logic [1:0]          fin_tn;
  logic [1:0]          fin_mm;
  logic [1:0]          end_tn;
  logic [1:0]          end_mm;
  logic [LEN_W+3:0]    acc_x10;
  logic [LEN_W+3:0]    acc_sum;
  logic [LEN_W-1:0]    acc_sat;
  logic [KIND_W-1:0]   kind;

  assign b        = item.data_byte;
  assign lc       = to_lower(b);
  assign blank    = is_blank(b);
  assign digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign tl_cur   = in_tok_r ? tl_r : '0;
  assign get_hit  = (tl_cur < TOKLEN_W'(3)) && (lc == get_char(tl_cur[1:0]));
  assign post_hit = (tl_cur < TOKLEN_W'(4)) && (lc == post_char(tl_cur[1:0]));

  // closing a token: the method token settles its candidates by length
  assign fin_tn = (tn_r == TOK_SAT) ? tn_r : tn_r + 2'd1;
  assign fin_mm = (tn_r == 2'd0) ? {mm_r[1] & (tl_r == TOKLEN_W'(4)),
                                    mm_r[0] & (tl_r == TOKLEN_W'(3))} : mm_r;
  assign end_tn = in_tok_r ? fin_tn : tn_r;
  assign end_mm = in_tok_r ? fin_mm : mm_r;

  // acc*10 + digit, saturate at the 31-bit limit
  assign acc_x10 = {3'b000, acc_r, 1'b0} + {1'b0, acc_r, 3'b000};
  assign acc_sum = acc_x10 + {{(LEN_W-0){1'b0}}, (b[3:0] - CH_ZERO[3:0])};
  assign acc_sat = (acc_sum > {4'b0000, LEN_MAX}) ? LEN_MAX : acc_sum[LEN_W-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    cr_nxt       = cr_r;
    tn_nxt       = tn_r;
    in_tok_nxt   = in_tok_r;
    tl_nxt       = tl_r;
    mm_nxt       = mm_r;
    nonempty_nxt = nonempty_r;
    hmi_nxt      = hmi_r;
    np_nxt       = np_r;
    neg_nxt      = neg_r;
    acc_nxt      = acc_r;
    cl_nxt       = cl_r;
    br_nxt       = br_r;
    tb_nxt       = tb_r;
    root_nxt     = root_r;
    post_nxt     = post_r;
    kind         = KIND_OTHER;

    if (item.func) begin
      phase_nxt    = PH_LINE;
      cr_nxt       = 1'b0;
      tn_nxt       = 2'd0;
      in_tok_nxt   = 1'b0;
      tl_nxt       = '0;
      mm_nxt       = 2'b11;
      nonempty_nxt = 1'b0;
      hmi_nxt      = '0;
      np_nxt       = NUM_PREFIX;
      neg_nxt      = 1'b0;
      acc_nxt      = '0;
      cl_nxt       = '0;
      br_nxt       = '0;
      tb_nxt       = '0;
      root_nxt     = 1'b0;
      post_nxt     = 1'b0;
    end else if (phase_r != PH_DONE && phase_r != PH_BAD) begin
      if (tb_r >= TOTAL_LIMIT) begin
        phase_nxt = PH_BAD;
      end else begin
        tb_nxt = tb_r + TOTAL_W'(1);
        if (phase_r == PH_BODY) begin
          kind   = KIND_BODY;
          br_nxt = br_r - LEN_W'(1);
          if (br_r == LEN_W'(1)) phase_nxt = PH_DONE;
        end else if (cr_r) begin
          if (b == CH_LF) begin
            // end of line: clear per-line state
            cr_nxt       = 1'b0;
            nonempty_nxt = 1'b0;
            hmi_nxt      = '0;
            np_nxt       = NUM_PREFIX;
            neg_nxt      = 1'b0;
            acc_nxt      = '0;
            tn_nxt       = 2'd0;
            in_tok_nxt   = 1'b0;
            tl_nxt       = '0;
            if (phase_r == PH_LINE) begin
              mm_nxt = end_mm;
              if (end_tn != TOK_SAT || end_mm == 2'b00) begin
                phase_nxt = PH_BAD;
              end else begin
                post_nxt  = end_mm[1];
                phase_nxt = PH_HEADER;
              end
            end else if (!nonempty_r) begin
              if (post_r && cl_r != '0) begin
                phase_nxt = PH_BODY;
                br_nxt    = cl_r;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else if (hmi_r == HDR_FULL) begin
              cl_nxt = neg_r ? '0 : acc_r;
            end
          end else begin
            phase_nxt = PH_BAD;
          end
        end else if (b == CH_CR) begin
          cr_nxt = 1'b1;
        end else if (b == CH_LF) begin
          phase_nxt = PH_BAD;
        end else begin
          nonempty_nxt = 1'b1;
          if (phase_r == PH_LINE) begin
            if (blank) begin
              if (in_tok_r) begin
                tn_nxt     = fin_tn;
                mm_nxt     = fin_mm;
                in_tok_nxt = 1'b0;
              end
            end else begin
              in_tok_nxt = 1'b1;
              tl_nxt     = (tl_cur == TOKLEN_SAT) ? tl_cur : tl_cur + TOKLEN_W'(1);
              case (tn_r)
                2'd0: begin
                  if (tl_cur >= TOKEN_LIMIT) phase_nxt = PH_BAD;
                  else mm_nxt = {mm_r[1] & post_hit, mm_r[0] & get_hit};
                end
                2'd1: begin
                  if (tl_cur >= PATH_LIMIT) begin
                    phase_nxt = PH_BAD;
                  end else begin
                    root_nxt = (tl_cur == '0) && (b == CH_SLASH);
                    kind     = KIND_PATH;
                  end
                end
                2'd2: begin
                  if (tl_cur >= TOKEN_LIMIT) phase_nxt = PH_BAD;
                end
                default: ;
              endcase
            end
          end else begin
            case (np_r)
              NUM_PREFIX: begin
                if (hmi_r < HDR_FULL && lc == hdr_char(hmi_r)) begin
                  hmi_nxt = hmi_r + 4'd1;
                  if (hmi_r == HDR_LAST) np_nxt = NUM_SIGN;
                end else begin
                  np_nxt = NUM_SKIP;
                end
              end
              NUM_SIGN, NUM_DIGITS: begin
                if (np_r == NUM_SIGN && blank) begin
                  np_nxt = np_r;
                end else if (np_r == NUM_SIGN && (b == CH_PLUS || b == CH_MINUS)) begin
                  neg_nxt = (b == CH_MINUS);
                  np_nxt  = NUM_DIGITS;
                end else if (digit) begin
                  acc_nxt = acc_sat;
                  np_nxt  = NUM_DIGITS;
                end else begin
                  np_nxt = NUM_SKIP;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    res.status         = (phase_nxt == PH_BAD)  ? STATUS_BAD :
                         (phase_nxt == PH_DONE) ? STATUS_COMPLETE : STATUS_INCOMPLETE;
    res.method_post    = post_nxt;
    res.content_length = cl_nxt;
    res.byte_out       = b;
    res.byte_kind      = kind;
    res.path_is_root   = root_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LINE;
      cr_r       <= 1'b0;
      tn_r       <= 2'd0;
      in_tok_r   <= 1'b0;
      tl_r       <= '0;
      mm_r       <= 2'b11;
      nonempty_r <= 1'b0;
      hmi_r      <= '0;
      np_r       <= NUM_PREFIX;
      neg_r      <= 1'b0;
      acc_r      <= '0;
      cl_r       <= '0;
      br_r       <= '0;
      tb_r       <= '0;
      root_r     <= 1'b0;
      post_r     <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      cr_r       <= cr_nxt;
      tn_r       <= tn_nxt;
      in_tok_r   <= in_tok_nxt;
      tl_r       <= tl_nxt;
      mm_r       <= mm_nxt;
      nonempty_r <= nonempty_nxt;
      hmi_r      <= hmi_nxt;
      np_r       <= np_nxt;
      neg_r      <= neg_nxt;
      acc_r      <= acc_nxt;
      cl_r       <= cl_nxt;
      br_r       <= br_nxt;
      tb_r       <= tb_nxt;
      root_r     <= root_nxt;
      post_r     <= post_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/http_request_header_parser.sv
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-per-beat HTTP/1.1 request header parser: method, path, length, body.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  in_      | input     | in_valid/in_stall | func, data_byte
//  out_     | output    | out_valid/out_stall | status, method_post, content_length,
//           |           |                   | byte_out, byte_kind, path_is_root
//
//  One byte per cycle sustained while out_stall is low; each accepted beat gives one result.
//  Path of a beat: input register, one pass of the parse logic, result register.
//  Reset (synchronous, rst_n low) empties both registers and puts the parser at
//  the start of a request line; no clearing pass is needed.
//  A stalled result holds the input side only once the input register is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_header_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [hrp_pkg::DATA_W-1:0] in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hrp_pkg::STAT_W-1:0] out_status,
  output logic                       out_method_post,
  output logic [hrp_pkg::LEN_W-1:0]  out_content_length,
  output logic [hrp_pkg::DATA_W-1:0] out_byte_out,
  output logic [hrp_pkg::KIND_W-1:0] out_byte_kind,
  output logic                       out_path_is_root
);
  import hrp_pkg::*;

  logic        in_v_r;
  logic        out_v_r;
  hrp_item_t   item_r;
  hrp_result_t res_r;
  hrp_result_t res;
  logic        advance;
  logic        in_take;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  hrp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) in_v_r <= 1'b1;
      else if (advance) in_v_r <= 1'b0;
      if (advance) out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  // payload: capture on beat, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func      <= in_func;
      item_r.data_byte <= in_data_byte;
    end
    if (advance) res_r <= res;
  end

  assign out_valid          = out_v_r;
  assign out_status         = res_r.status;
  assign out_method_post    = res_r.method_post;
  assign out_content_length = res_r.content_length;
  assign out_byte_out       = res_r.byte_out;
  assign out_byte_kind      = res_r.byte_kind;
  assign out_path_is_root   = res_r.path_is_root;

endmodule

`default_nettype wire

>>> rtl/hrp_checker.sv
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks of the request parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_request_header_parser_assert.svh"

module hrp_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_func,
  input  logic [hrp_pkg::DATA_W-1:0] in_data_byte,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [hrp_pkg::STAT_W-1:0] out_status,
  input  logic                       out_method_post,
  input  logic [hrp_pkg::LEN_W-1:0]  out_content_length,
  input  logic [hrp_pkg::DATA_W-1:0] out_byte_out,
  input  logic [hrp_pkg::KIND_W-1:0] out_byte_kind,
  input  logic                       out_path_is_root
);
  import hrp_pkg::*;

  logic out_hold;
  logic body_beat;
  logic path_beat;
  logic in_unused;

  assign out_hold  = out_valid && out_stall;
  assign body_beat = out_valid && (out_byte_kind == KIND_BODY);
  assign path_beat = out_valid && (out_byte_kind == KIND_PATH);
  assign in_unused = in_valid ^ in_func ^ (^in_data_byte);

  // a stalled result beat stays put
  `HRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_byte_out) && $stable(out_status))

  // body bytes exist only for POST and never on a bad request
  `HRP_ASSERT_IMPL(a_body_post, clk, rst_n, body_beat, out_method_post && out_status != STATUS_BAD)

  // path bytes come from the request line, before the method is committed
  `HRP_ASSERT_IMPL(a_path_line, clk, rst_n, path_beat, out_status == STATUS_INCOMPLETE && !out_method_post)

  // the input side backs up only behind a stalled result
  `HRP_ASSERT_IMPL(a_stall_src, clk, rst_n, in_stall && !in_unused, out_hold)

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (.*);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: HTTP request header parser testbench
// Streams request bytes through the parser under random idle and stall,
// predicts every result beat in step with accepted input, compares per field.
// ----------------------------------------------------------------------------

module tb;
  import hrp_pkg::*;

  // Characters and codes the parser cares about
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam string LEN_HDR       = "content-length:";
  localparam int    LEN_HDR_CHARS = 15;
  localparam string GET_TXT       = "get";
  localparam string POST_TXT      = "post";
  localparam logic [31:0] LEN_MAX = 32'h7FFF_FFFF;
  localparam int unsigned TOKLEN_SAT = 16'hFFFF;
  localparam int unsigned LINE_SAT   = 4095;

  localparam logic [1:0] CAND_GET  = 2'b01;
  localparam logic [1:0] CAND_POST = 2'b10;

  localparam int IDLE_SET  [4] = '{0, 56, 0, 35};
  localparam int STALL_SET [4] = '{0, 0, 56, 35};
  localparam int BEATS_PER_PHASE = 150;

  typedef enum logic [2:0] {
    PH_REQ_LINE, PH_HEADERS, PH_BODY, PH_COMPLETE, PH_BAD
  } parse_phase_t;

  typedef enum logic [1:0] {NUM_PREFIX, NUM_LEAD, NUM_DIGITS, NUM_SKIP} len_scan_t;

  typedef struct {
    hrp_item_t beat;
    int        idle_pct;
    int        stall_pct;
  } stim_beat_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_func = 1'b0;
  logic [DATA_W-1:0]   in_data_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic                out_method_post;
  logic [LEN_W-1:0]    out_content_length;
  logic [DATA_W-1:0]   out_byte_out;
  logic [KIND_W-1:0]   out_byte_kind;
  logic                out_path_is_root;

  stim_beat_t  request_beats[$];
  hrp_result_t parse_results_due[$];
  logic [7:0]  req_buf[$];
  stim_beat_t  next_beat;
  hrp_result_t oldest_due;
  int          cur_idle = 0;
  int          cur_stall = 0;
  int          stall_pct = 0;
  int          err_cnt = 0;

  // Parser state as the predictor sees it
  parse_phase_t phase_q;
  len_scan_t    num_state;
  bit           cr_seen, in_tok, num_neg, post_q, root_q;
  bit [1:0]     method_cand;
  int unsigned  tok_count, tok_len, line_len, hdr_idx, req_bytes;
  logic [31:0]  len_acc, clen_q, body_left;

  always #5 clk = ~clk;

  http_request_header_parser i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_method_post   (out_method_post),
    .out_content_length(out_content_length),
    .out_byte_out      (out_byte_out),
    .out_byte_kind     (out_byte_kind),
    .out_path_is_root  (out_path_is_root)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_HT || c == CH_VT || c == CH_FF;
  endfunction

  function automatic void clear_line_state();
    cr_seen = 0; line_len = 0; hdr_idx = 0; num_state = NUM_PREFIX;
    num_neg = 0; len_acc = '0; tok_count = 0; in_tok = 0; tok_len = 0;
  endfunction

  function automatic void restart_request();
    phase_q = PH_REQ_LINE;
    clear_line_state();
    method_cand = CAND_GET | CAND_POST;
    clen_q = '0; body_left = '0; req_bytes = 0; root_q = 0; post_q = 0;
  endfunction

  function automatic void close_token();
    if (tok_count == 0) begin
      if (tok_len != 3) method_cand &= CAND_POST;
      if (tok_len != 4) method_cand &= CAND_GET;
    end
    if (tok_count < 3) tok_count++;
    in_tok = 0;
  endfunction

  function automatic hrp_result_t parse_byte(input logic func, input logic [7:0] b);
    hrp_result_t res;
    logic [KIND_W-1:0] kind;
    logic [7:0] lc;
    logic [31:0] d;
    int unsigned tok_limit;
    kind = KIND_OTHER;
    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    d = 32'(b) - 32'd48;
    if (func) begin
      restart_request();
    end else if (phase_q != PH_COMPLETE && phase_q != PH_BAD) begin
      if (req_bytes >= MAX_REQUEST_BYTES) begin
        phase_q = PH_BAD;
      end else begin
        req_bytes++;
        if (phase_q == PH_BODY) begin
          kind = KIND_BODY;
          body_left--;
          if (body_left == 0) phase_q = PH_COMPLETE;
        end else if (cr_seen) begin
          if (b != CH_LF) begin
            phase_q = PH_BAD;
          end else if (phase_q == PH_REQ_LINE) begin
            if (in_tok) close_token();
            if (tok_count < 3 || method_cand == 2'b00) begin
              phase_q = PH_BAD;
            end else begin
              post_q = method_cand[1];
              phase_q = PH_HEADERS;
              clear_line_state();
            end
          end else begin
            if (line_len == 0) begin
              if (post_q && clen_q > 0) begin
                phase_q = PH_BODY;
                body_left = clen_q;
              end else begin
                phase_q = PH_COMPLETE;
              end
            end else if (hdr_idx == LEN_HDR_CHARS) begin
              clen_q = num_neg ? 32'd0 : len_acc;
            end
            clear_line_state();
          end
        end else if (b == CH_CR) begin
          cr_seen = 1;
        end else if (b == CH_LF) begin
          phase_q = PH_BAD;
        end else begin
          if (line_len < LINE_SAT) line_len++;
          if (phase_q == PH_REQ_LINE) begin
            if (is_blank(b)) begin
              if (in_tok) close_token();
            end else begin
              if (!in_tok) begin
                in_tok = 1;
                tok_len = 0;
              end
              tok_limit = (tok_count == 1) ? MAX_PATH_CHARS : MAX_TOKEN_CHARS;
              if (tok_count < 3 && tok_len >= tok_limit) begin
                phase_q = PH_BAD;
              end else begin
                if (tok_count == 0) begin
                  if (!(tok_len < 3 && lc == GET_TXT[tok_len])) method_cand &= CAND_POST;
                  if (!(tok_len < 4 && lc == POST_TXT[tok_len])) method_cand &= CAND_GET;
                end else if (tok_count == 1) begin
                  root_q = (tok_len == 0 && b == "/");
                  kind = KIND_PATH;
                end
                if (tok_len < TOKLEN_SAT) tok_len++;
              end
            end
          end else if (num_state == NUM_PREFIX) begin
            if (hdr_idx < LEN_HDR_CHARS && lc == LEN_HDR[hdr_idx]) begin
              hdr_idx++;
              if (hdr_idx == LEN_HDR_CHARS) num_state = NUM_LEAD;
            end else begin
              num_state = NUM_SKIP;
            end
          end else if (num_state != NUM_SKIP && !(num_state == NUM_LEAD && is_blank(b))) begin
            if (num_state == NUM_LEAD && (b == "+" || b == "-")) begin
              num_neg = (b == "-");
              num_state = NUM_DIGITS;
            end else if (b >= "0" && b <= "9") begin
              // saturate the magnitude instead of wrapping
              if (len_acc > (LEN_MAX - d) / 10) len_acc = LEN_MAX;
              else len_acc = len_acc * 10 + d;
              num_state = NUM_DIGITS;
            end else begin
              num_state = NUM_SKIP;
            end
          end
        end
      end
    end
    res.status = (phase_q == PH_COMPLETE) ? STATUS_COMPLETE :
                 (phase_q == PH_BAD) ? STATUS_BAD : STATUS_INCOMPLETE;
    res.method_post    = post_q;
    res.content_length = clen_q[LEN_W-1:0];
    res.byte_out       = b;
    res.byte_kind      = kind;
    res.path_is_root   = root_q;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders
  // --------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    req_buf.push_back(b);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_case(logic [7:0] c);
    return (c >= "a" && c <= "z" && $urandom_range(1) == 1) ? c - 8'd32 : c;
  endfunction

  function automatic void add_word(string s);
    for (int i = 0; i < s.len(); i++) add_byte(rand_case(s[i]));
  endfunction

  function automatic void add_blanks(int n);
    repeat (n) begin
      case ($urandom_range(3))
        0:       add_byte(CH_SP);
        1:       add_byte(CH_HT);
        2:       add_byte(CH_VT);
        default: add_byte(CH_FF);
      endcase
    end
  endfunction

  function automatic void add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function automatic void push_beat(logic func, logic [7:0] b);
    stim_beat_t s;
    s.beat.func      = func;
    s.beat.data_byte = b;
    s.idle_pct       = cur_idle;
    s.stall_pct      = cur_stall;
    request_beats.push_back(s);
  endfunction

  function automatic void flush_request(bit with_start, logic [7:0] start_byte);
    if (with_start) push_beat(1'b1, start_byte);
    foreach (req_buf[i]) push_beat(1'b0, req_buf[i]);
    req_buf.delete();
  endfunction

  function automatic void add_noise_header();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      add_word(LEN_HDR);
      add_blanks($urandom_range(0, 2));
      case ($urandom_range(5))
        0:       add_byte("-");
        1:       add_byte("+");
        default: begin end
      endcase
      pick = $urandom_range(9);
      // long digit strings drive the saturation path
      if (pick < 3) repeat ($urandom_range(10, 12)) add_byte(8'($urandom_range(48, 57)));
      else if (pick < 8) repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(48, 57)));
      if ($urandom_range(3) == 0) add_byte(8'($urandom_range(33, 126)));
    end else if (pick < 7) begin
      add_word(LEN_HDR.substr(0, $urandom_range(0, LEN_HDR_CHARS - 2)));
      add_text("x: 9");
    end else begin
      repeat ($urandom_range(1, 6)) add_byte(rand_case(8'($urandom_range(97, 122))));
      add_text(": ");
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(33, 126)));
    end
  endfunction

  function automatic int gen_request();
    int  sel, body_len, idx, keep, n_beats;
    bit  is_post, with_start;
    req_buf.delete();
    is_post = 0;
    sel = $urandom_range(99);
    if ($urandom_range(9) == 0) add_blanks($urandom_range(1, 2));
    if (sel < 45) begin
      add_word(GET_TXT);
    end else if (sel < 85) begin
      add_word(POST_TXT);
      is_post = 1;
    end else if (sel < 90) begin
      add_word((sel % 2 == 0) ? "ge" : "postt");
    end else begin
      repeat ($urandom_range(1, MAX_TOKEN_CHARS + 2))
        add_byte(rand_case(8'($urandom_range(97, 122))));
    end
    // now and then cut the request line short of its three tokens
    if ($urandom_range(19) != 0) begin
      add_blanks($urandom_range(1, 2));
      add_byte("/");
      if ($urandom_range(2) != 0) repeat ($urandom_range(1, 6))
        add_byte(8'($urandom_range(33, 126)));
      add_blanks($urandom_range(1, 2));
      if ($urandom_range(5) != 0) add_text("HTTP/1.1");
      else repeat ($urandom_range(MAX_TOKEN_CHARS - 2, MAX_TOKEN_CHARS + 2))
        add_byte(8'($urandom_range(33, 126)));
      if ($urandom_range(9) == 0) begin
        add_blanks(1);
        add_text("x");
      end
    end
    if ($urandom_range(9) == 0) add_blanks(1);
    add_crlf();
    repeat ($urandom_range(0, 2)) begin
      add_noise_header();
      add_crlf();
    end
    body_len = $urandom_range(0, 12);
    if ($urandom_range(4) != 0) begin
      add_word(LEN_HDR);
      add_blanks($urandom_range(0, 2));
      if ($urandom_range(4) == 0) add_byte("+");
      add_text($sformatf("%0d", body_len));
      add_crlf();
    end
    add_crlf();
    if (is_post) repeat (body_len) add_byte(8'($urandom_range(0, 255)));
    sel = $urandom_range(99);
    if (sel < 8) begin
      idx = $urandom_range(0, req_buf.size() - 1);
      case ($urandom_range(2))
        0:       req_buf[idx] = CH_CR;
        1:       req_buf[idx] = CH_LF;
        default: req_buf[idx] = 8'($urandom_range(0, 255));
      endcase
    end else if (sel < 12) begin
      keep = $urandom_range(1, req_buf.size() - 1);
      while (req_buf.size() > keep) void'(req_buf.pop_back());
    end
    with_start = ($urandom_range(9) != 0);
    n_beats = req_buf.size() + (with_start ? 1 : 0);
    // trailing bytes after the end are ignored by the parser; not counted
    if ($urandom_range(6) == 0) repeat ($urandom_range(1, 3))
      add_byte(8'($urandom_range(0, 255)));
    flush_request(with_start, 8'($urandom_range(0, 255)));
    return n_beats;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predict on accept, then load the next beat unless idling
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        parse_results_due.push_back(parse_byte(in_func, in_data_byte));
      if (!in_valid || !in_stall) begin
        if (request_beats.size() != 0 && $urandom_range(99) >= request_beats[0].idle_pct) begin
          next_beat = request_beats.pop_front();
          in_valid     <= 1'b1;
          in_func      <= next_beat.beat.func;
          in_data_byte <= next_beat.beat.data_byte;
          stall_pct    <= next_beat.stall_pct;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parse_results_due.size() == 0) begin
          $error("result beat with no pending expectation");
          err_cnt++;
        end else begin
          oldest_due = parse_results_due.pop_front();
          check_field("status", oldest_due.status, out_status);
          check_field("method_post", oldest_due.method_post, out_method_post);
          check_field("content_length", oldest_due.content_length, out_content_length);
          check_field("byte_out", oldest_due.byte_out, out_byte_out);
          check_field("byte_kind", oldest_due.byte_kind, out_byte_kind);
          check_field("path_is_root", oldest_due.path_is_root, out_path_is_root);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n_beats;
    restart_request();

    // directed: lowercase GET of the index page straight out of reset
    cur_idle = 0;
    cur_stall = 0;
    add_text("get / x");
    add_crlf();
    add_crlf();
    flush_request(0, 8'h00);
    // bare LF, then a NUL byte that is ignored once bad
    add_text("A");
    add_byte(CH_LF);
    add_byte(8'h00);
    flush_request(1, 8'hFF);
    // bare CR
    add_text("X");
    add_byte(CH_CR);
    add_text("Z");
    flush_request(1, 8'h80);
    // request line with a single token
    add_text("get");
    add_crlf();
    flush_request(1, 8'h7F);

    for (int ph = 0; ph < 4; ph++) begin
      cur_idle  = IDLE_SET[ph];
      cur_stall = STALL_SET[ph];
      n_beats = 0;
      while (n_beats < BEATS_PER_PHASE) n_beats += gen_request();
    end

    cur_idle = 0;
    cur_stall = 0;
    // longest legal path, with saturating, negative and empty length values
    add_word("get /");
    repeat (MAX_PATH_CHARS - 1) add_byte(8'($urandom_range(33, 126)));
    add_text(" h");
    add_crlf();
    add_text("Content-Length: 2147483648");
    add_crlf();
    add_word("content-length:");
    add_byte(CH_HT);
    add_text("-5");
    add_crlf();
    add_text("content-length: +");
    add_crlf();
    add_text("CONTENT-LENGTH:2147483647");
    add_crlf();
    add_crlf();
    flush_request(1, 8'h00);
    // path one byte too long
    add_text("get /");
    repeat (MAX_PATH_CHARS) add_byte(8'($urandom_range(33, 126)));
    flush_request(1, 8'h01);
    // body that runs past the request size limit
    add_text("post / h");
    add_crlf();
    add_text("Content-Length: 5000");
    add_crlf();
    add_crlf();
    repeat (MAX_REQUEST_BYTES) add_byte(8'($urandom_range(0, 255)));
    flush_request(1, 8'h55);
    add_text("GET ? h");
    add_crlf();
    add_crlf();
    flush_request(1, 8'hAA);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (request_beats.size() != 0 || in_valid || parse_results_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && parse_results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> http_request_header_parser.f
+incdir+rtl
rtl/hrp_pkg.sv
rtl/hrp_parse_core.sv
rtl/http_request_header_parser.sv
rtl/hrp_checker.sv
dv/tb.sv
